>>> hdl/avpq_pkg.sv
// Package for the absolute-value priority queue.
// Holds capacity constants, controller states and the command/status structs.
// No dependencies.
package avpq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int AW        = $clog2(CAPACITY + 1);
    localparam int CW        = $clog2(CAPACITY + 1);
    localparam int MW        = 31;
    localparam int RAM_DEPTH = 1 << AW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_WAIT,
        S_PUSH_CMP,
        S_POP_RD,
        S_POP_WAIT,
        S_POP_SEL,
        S_POP_LAST,
        S_POP_LWAIT,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic push_start;
        logic push_rd;
        logic push_step;
        logic push_done;
        logic root_rd;
        logic sel_heap;
        logic last_rd;
        logic last_cap;
        logic dn_rd;
        logic dn_step;
        logic dn_done;
        logic out_zero;
    } t_cmd;

    typedef struct packed {
        logic is_zero;
        logic full;
        logic both_empty;
        logic push_go;
        logic dn_go;
        logic dn_more;
    } t_sts;

endpackage

>>> hdl/avpq_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module avpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> hdl/avpq_datapath.sv
// Datapath: two heap memories, counts, sift-up and sift-down registers.
// Depends on avpq_pkg and avpq_ram.
module avpq_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_value,
    input  avpq_pkg::t_cmd     i_cmd,
    output avpq_pkg::t_sts     o_sts,
    output logic [31:0]        o_result
);
    import avpq_pkg::*;

    logic [CW-1:0] r_pcnt, r_ncnt;
    logic          r_heap;
    logic [MW-1:0] r_key, r_top, r_last;
    logic [AW-1:0] r_idx, r_child;
    logic [MW-1:0] r_lchild;
    logic          r_phase;
    logic [31:0]   r_result;

    logic          we_p, we_n;
    logic [AW-1:0] addr;
    logic [MW-1:0] wdata, rd_p, rd_n, rd;
    logic [CW-1:0] cnt;
    logic [MW-1:0] mag;
    logic          neg_first;
    logic [AW:0]   c_ext;
    logic          has_r, take_r;
    logic [MW-1:0] best;
    logic [AW-1:0] dn_idx;

    assign mag = (i_value == 32'h8000_0000) ? {MW{1'b1}} : MW'(-i_value);

    avpq_ram #(.WIDTH(MW), .DEPTH(RAM_DEPTH)) u_pos (
        .i_clk(i_clk), .i_we(we_p), .i_addr(addr), .i_wdata(wdata), .o_rdata(rd_p)
    );
    avpq_ram #(.WIDTH(MW), .DEPTH(RAM_DEPTH)) u_neg (
        .i_clk(i_clk), .i_we(we_n), .i_addr(addr), .i_wdata(wdata), .o_rdata(rd_n)
    );

    assign rd  = r_heap ? rd_n : rd_p;
    assign cnt = r_heap ? r_ncnt : r_pcnt;

    assign neg_first = (r_ncnt != '0) && ((r_pcnt == '0) || (rd_n <= rd_p));

    // pick the smaller child: r_lchild holds the left, rd the right
    assign c_ext  = {1'b0, r_child};
    assign has_r  = (c_ext + (AW+1)'(1)) <= (AW+1)'(cnt);
    assign take_r = has_r && (rd < r_lchild);
    assign best   = take_r ? rd : r_lchild;
    assign dn_idx = take_r ? r_child + AW'(1) : r_child;

    always_comb begin
        we_p = 1'b0;
        we_n = 1'b0;
        addr = r_idx;
        wdata = r_key;
        if (i_cmd.push_rd) begin
            addr = r_idx >> 1;
        end else if (i_cmd.push_step) begin
            wdata = rd;
            we_p = !r_heap;
            we_n = r_heap;
        end else if (i_cmd.push_done) begin
            we_p = !r_heap;
            we_n = r_heap;
        end else if (i_cmd.root_rd) begin
            addr = AW'(1);
        end else if (i_cmd.last_rd) begin
            addr = AW'(cnt);
        end else if (i_cmd.dn_rd) begin
            addr = r_phase ? r_child + AW'(1) : r_child;
        end else if (i_cmd.dn_step) begin
            wdata = best;
            we_p = !r_heap;
            we_n = r_heap;
        end else if (i_cmd.dn_done) begin
            wdata = r_last;
            we_p = !r_heap && (cnt != '0);
            we_n = r_heap && (cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= '0;
            r_ncnt <= '0;
        end else begin
            if (i_cmd.push_start) begin
                if (r_heap) r_ncnt <= r_ncnt + CW'(1);
                else        r_pcnt <= r_pcnt + CW'(1);
            end
            if (i_cmd.last_cap) begin
                if (r_heap) r_ncnt <= r_ncnt - CW'(1);
                else        r_pcnt <= r_pcnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= i_cmd.dn_rd;
        if (i_cmd.load_in) begin
            r_heap <= i_value[31];
            r_key  <= i_value[31] ? mag : i_value[MW-1:0];
            r_idx  <= i_value[31] ? AW'(r_ncnt + CW'(1)) : AW'(r_pcnt + CW'(1));
        end
        if (i_cmd.push_step) begin
            r_idx <= r_idx >> 1;
        end
        if (i_cmd.sel_heap) begin
            r_heap <= neg_first;
            r_top  <= neg_first ? rd_n : rd_p;
        end
        if (i_cmd.last_cap) begin
            r_last  <= rd;
            r_idx   <= AW'(1);
            r_child <= AW'(2);
        end
        if (i_cmd.dn_rd && r_phase) begin
            r_lchild <= rd;
        end
        if (i_cmd.dn_step) begin
            r_idx   <= dn_idx;
            r_child <= AW'({dn_idx, 1'b0});
        end
        if (i_cmd.out_zero) begin
            r_result <= '0;
        end else if (i_cmd.dn_done) begin
            r_result <= r_heap ? -{1'b0, r_top} : {1'b0, r_top};
        end
    end

    assign o_sts.is_zero    = (i_value == '0);
    assign o_sts.full       = i_value[31] ? (r_ncnt >= CW'(CAPACITY))
                                          : (r_pcnt >= CW'(CAPACITY));
    assign o_sts.both_empty = (r_pcnt == '0) && (r_ncnt == '0);
    assign o_sts.push_go    = (r_idx > AW'(1)) && (r_key < rd);
    assign o_sts.dn_more    = ({1'b0, r_child} <= (AW+1)'(cnt));
    assign o_sts.dn_go      = r_last > best;
    assign o_result         = r_result;
endmodule

>>> hdl/absolute_value_priority_queue_top.sv
// Absolute-value priority queue, top level.
// Insert: accept; per heap level read parent, wait, compare; a full heap drops the word.
// Remove: read both roots, pick the heap, read its last word, then per level walked down
// read both children and compare, then finish and output; zero if both heaps are empty.
// One word at a time; input stalls until the result is taken; memory reads set the rate.
// Synchronous active-low reset empties both heaps; no clearing pass.
module absolute_value_priority_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_removed
);
    import avpq_pkg::*;

    t_state r_state, n_state;
    t_cmd   cmd;
    t_sts   sts;
    logic   acc;

    assign acc = i_valid && !o_stall;

    avpq_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_value(i_value),
        .i_cmd(cmd), .o_sts(sts), .o_result(o_removed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        cmd = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    cmd.load_in = 1'b1;
                    if (sts.is_zero) begin
                        if (sts.both_empty) begin
                            cmd.out_zero = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end else if (!sts.full) begin
                        n_state = S_PUSH_RD;
                    end
                end
            end
            S_PUSH_RD: begin
                cmd.push_rd = 1'b1;
                n_state = S_PUSH_WAIT;
            end
            S_PUSH_WAIT: begin
                cmd.push_rd = 1'b1;
                n_state = S_PUSH_CMP;
            end
            S_PUSH_CMP: begin
                if (sts.push_go) begin
                    cmd.push_step = 1'b1;
                    n_state = S_PUSH_RD;
                end else begin
                    cmd.push_done = 1'b1;
                    cmd.push_start = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_POP_RD: begin
                cmd.root_rd = 1'b1;
                n_state = S_POP_WAIT;
            end
            S_POP_WAIT: begin
                cmd.root_rd = 1'b1;
                n_state = S_POP_SEL;
            end
            S_POP_SEL: begin
                cmd.sel_heap = 1'b1;
                n_state = S_POP_LAST;
            end
            S_POP_LAST: begin
                cmd.last_rd = 1'b1;
                n_state = S_POP_LWAIT;
            end
            S_POP_LWAIT: begin
                cmd.last_cap = 1'b1;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (sts.dn_more) begin
                    cmd.dn_rd = 1'b1;
                    n_state = S_DN_WAIT;
                end else begin
                    cmd.dn_done = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DN_WAIT: begin
                cmd.dn_rd = 1'b1;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (sts.dn_go) begin
                    cmd.dn_step = 1'b1;
                    n_state = S_DN_RD;
                end else begin
                    cmd.dn_done = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && sts.is_zero |=> r_state != S_IDLE)
        else $error("removal word did not start work");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_removed))
        else $error("stalled result changed");
endmodule

>>> tb/sv/absolute_value_priority_queue_top_test.sv
// Testbench for the absolute-value priority queue top level.
// Drives signed words with random idling and stall, and checks each removed word
// against a two-heap scoreboard; depends on avpq_pkg and the top-level RTL.
class avpq_scoreboard;
    logic [30:0] pos_heap [1:avpq_pkg::CAPACITY];
    logic [30:0] neg_heap [1:avpq_pkg::CAPACITY];
    int          pos_cnt;
    int          neg_cnt;
    logic [31:0] removed_q [$];
    int          errors;

    function new();
        pos_cnt = 0;
        neg_cnt = 0;
        errors  = 0;
    endfunction

    function void heap_insert(bit is_neg, logic [30:0] v);
        int i;
        if (is_neg) begin
            if (neg_cnt >= avpq_pkg::CAPACITY) return;
            neg_cnt++;
            i = neg_cnt;
            while (i > 1 && v < neg_heap[i / 2]) begin
                neg_heap[i] = neg_heap[i / 2];
                i = i / 2;
            end
            neg_heap[i] = v;
        end else begin
            if (pos_cnt >= avpq_pkg::CAPACITY) return;
            pos_cnt++;
            i = pos_cnt;
            while (i > 1 && v < pos_heap[i / 2]) begin
                pos_heap[i] = pos_heap[i / 2];
                i = i / 2;
            end
            pos_heap[i] = v;
        end
    endfunction

    function logic [30:0] heap_extract(bit is_neg);
        logic [30:0] top;
        logic [30:0] last;
        logic [30:0] h [1:avpq_pkg::CAPACITY];
        int          n;
        int          parent;
        int          child;
        if (is_neg) begin
            h = neg_heap;
            n = neg_cnt;
        end else begin
            h = pos_heap;
            n = pos_cnt;
        end
        top  = h[1];
        last = h[n];
        n--;
        parent = 1;
        child  = 2;
        while (child <= n) begin
            if (child < n && h[child + 1] < h[child]) child++;
            if (last <= h[child]) break;
            h[parent] = h[child];
            parent = child;
            child  = child * 2;
        end
        if (n > 0) h[parent] = last;
        if (is_neg) begin
            neg_heap = h;
            neg_cnt  = n;
        end else begin
            pos_heap = h;
            pos_cnt  = n;
        end
        return top;
    endfunction

    function void note_input(logic [31:0] raw);
        logic [31:0] mag;
        if (raw != 0) begin
            if (!raw[31]) begin
                heap_insert(0, raw[30:0]);
            end else begin
                mag = -raw;
                if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
                heap_insert(1, mag[30:0]);
            end
        end else if (pos_cnt == 0 && neg_cnt == 0) begin
            removed_q.push_back(32'd0);
        end else if (neg_cnt != 0 && (pos_cnt == 0 || neg_heap[1] <= pos_heap[1])) begin
            mag = {1'b0, heap_extract(1)};
            removed_q.push_back(-mag);
        end else begin
            removed_q.push_back({1'b0, heap_extract(0)});
        end
    endfunction

    function void check_result(logic [31:0] actual);
        logic [31:0] want;
        if (removed_q.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, actual);
            errors++;
            return;
        end
        want = removed_q.pop_front();
        if (actual !== want) begin
            $display("%0t: removed mismatch, expected %h, actual %h", $time, want, actual);
            errors++;
        end
    endfunction
endclass

module absolute_value_priority_queue_top_test;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_removed;

    avpq_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int quiet_cycles = 0;
    localparam int WATCHDOG_LIMIT = 20000;

    absolute_value_priority_queue_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_removed(o_removed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_removed);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(logic [31:0] v);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(v);
    endtask

    function automatic logic [31:0] random_word(int zero_pct);
        int sel;
        sel = $urandom_range(99);
        if (sel < zero_pct) return 32'd0;
        sel = $urandom_range(9);
        case (sel)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom_range(1, 12);
            4, 5: return -$urandom_range(1, 12);
            default: return ($urandom() == 0) ? 32'd1 : $urandom();
        endcase
    endfunction

    task automatic run_random(int n, int ipct, int spct);
        idle_pct  = ipct;
        stall_pct = spct;
        repeat (n) send_word(random_word(45));
    endtask

    initial begin
        sb           = new();
        idle_pct     = 0;
        stall_pct    = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_value      = 32'd0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(32'd0);
        send_word(32'd5);
        send_word(-32'sd5);
        send_word(32'd0);
        send_word(32'd0);
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h8000_0001);
        send_word(32'd1);
        send_word(-32'sd1);
        send_word(32'hFFFF_FFFF);
        repeat (6) send_word(32'd0);
        send_word(-32'sd7);
        send_word(-32'sd3);
        send_word(32'd0);
        send_word(32'd9);
        repeat (3) send_word(32'd0);

        run_random(150, 0, 0);
        run_random(150, 78, 0);
        run_random(150, 0, 78);
        run_random(150, 34, 34);

        idle_pct  = 0;
        stall_pct = 0;
        repeat (avpq_pkg::CAPACITY + 6) send_word($urandom_range(1, 40000));
        repeat (130) send_word(-$urandom_range(1, 40000));
        idle_pct  = 34;
        stall_pct = 34;
        repeat (60) send_word(random_word(70));
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.removed_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
hdl/avpq_pkg.sv
hdl/avpq_ram.sv
hdl/avpq_datapath.sv
hdl/absolute_value_priority_queue_top.sv
tb/sv/absolute_value_priority_queue_top_test.sv
